[design/gaussian_pair_generator_running_max_assert.svh]
// assertion macros for the gaussian pair generator
`ifndef GAUSSIAN_PAIR_GENERATOR_RUNNING_MAX_ASSERT_SVH
`define GAUSSIAN_PAIR_GENERATOR_RUNNING_MAX_ASSERT_SVH

// property must hold on every clock edge outside reset
`define GPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent must hold in the cycle after the antecedent
`define GPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/gpg_pkg.sv]
// ----------------------------------------------------------------------------
// gpg_pkg
// shared widths, constants and arctangent table for the gaussian generator
// ----------------------------------------------------------------------------
package gpg_pkg;

  localparam int OUT_FRAC_BITS = 12;
  localparam int OUT_SHIFT     = 30 - OUT_FRAC_BITS;

  localparam logic [31:0] SEED_RESET      = 32'd12345;
  localparam logic [14:0] LCG_MULT        = 15'd16807;
  localparam logic [31:0] TWO_LN2_Q30     = 32'd1488522236;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
  localparam int          CORDIC_ITERS    = 28;
  localparam int          LOG_FRAC_BITS   = 28;

  // word handed from front part to back part
  typedef struct packed {
    logic [31:0] m1;
    logic [31:0] m2;
    logic        new_batch;
  } gpg_job_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

[design/gpg_if.sv]
// ----------------------------------------------------------------------------
// gpg channel interfaces
// valid/ready channels for input ticks, results and seed writes
// ----------------------------------------------------------------------------
interface gpg_in_if;
  logic valid;
  logic ready;
  logic new_batch;
  logic reseed;
  modport source (output valid, output new_batch, output reseed, input ready);
  modport sink (input valid, input new_batch, input reseed, output ready);
endinterface

interface gpg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] gauss_a;
  logic [15:0] gauss_b;
  logic [14:0] batch_max;
  modport source (output valid, output gauss_a, output gauss_b, output batch_max,
                  input ready);
  modport sink (input valid, input gauss_a, input gauss_b, input batch_max,
                output ready);
endinterface

interface gpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/gpg_front.sv]
// ----------------------------------------------------------------------------
// gpg_front
// seed register and generator: steps the state twice per tick
// ----------------------------------------------------------------------------
module gpg_front (
  input  logic              clk,
  input  logic              rst,
  gpg_in_if.sink            in_ch,
  gpg_cfg_if.sink           cfg,
  output logic              job_valid,
  output gpg_pkg::gpg_job_t job,
  input  logic              job_ready
);
  import gpg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL1 = 3'b010,
    ST_MUL2 = 3'b100
  } fstate_t;

  fstate_t     state;
  logic [31:0] seed;
  logic [31:0] lcg_state;
  logic [31:0] s1;
  logic        nb;
  logic [31:0] prod;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == ST_IDLE) && !job_valid;

  // one constant multiply per cycle, shared by both steps
  assign prod = (state == ST_MUL1) ? lcg_state * 32'(LCG_MULT) : s1 * 32'(LCG_MULT);

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg.valid) begin
      seed <= cfg.data;
    end
  end

  // generator sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lcg_state <= SEED_RESET;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            nb <= in_ch.new_batch;
            if (in_ch.reseed) begin
              lcg_state <= seed;
            end
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          s1    <= prod;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          lcg_state     <= prod;
          job.m1        <= s1 ^ 32'h80000000;
          job.m2        <= prod ^ 32'h80000000;
          job.new_batch <= nb;
          job_valid     <= 1'b1;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

[design/gpg_queue.sv]
// ----------------------------------------------------------------------------
// gpg_queue
// two-entry queue between generator and transform
// ----------------------------------------------------------------------------
module gpg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  input  gpg_pkg::gpg_job_t wr_data,
  output logic              wr_ready,
  output logic              rd_valid,
  output gpg_pkg::gpg_job_t rd_data,
  input  logic              rd_ready
);
  import gpg_pkg::*;

  gpg_job_t    mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[design/gpg_back.sv]
// ----------------------------------------------------------------------------
// gpg_back
// box-muller transform: log, square root, cordic, rounding, running maximum
// ----------------------------------------------------------------------------
module gpg_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  gpg_pkg::gpg_job_t job,
  output logic              job_ready,
  gpg_out_if.source         out_ch
);
  import gpg_pkg::*;

  typedef enum logic [9:0] {
    B_IDLE  = 10'b0000000001,
    B_NORM  = 10'b0000000010,
    B_LOG   = 10'b0000000100,
    B_MUL   = 10'b0000001000,
    B_SQRT  = 10'b0000010000,
    B_GAIN  = 10'b0000100000,
    B_ROT   = 10'b0001000000,
    B_QUAD  = 10'b0010000000,
    B_OUT   = 10'b0100000000,
    B_HOLD  = 10'b1000000000
  } bstate_t;

  bstate_t      state;
  logic [31:0]  m1;
  logic [31:0]  m2;
  logic [4:0]   e;
  logic [32:0]  x_log;
  logic [27:0]  frac;
  logic [4:0]   cnt;
  logic [33:0]  lval;
  logic [63:0]  prod_l;
  logic [31:0]  rad;
  logic [45:0]  sq_v;
  logic [45:0]  sq_res;
  logic [45:0]  sq_bit;
  logic [35:0]  cx;
  logic [35:0]  cy;
  logic [33:0]  cz;
  logic [1:0]   quad;
  logic [14:0]  rmax;
  logic [15:0]  oa;
  logic [15:0]  ob;

  // combinational helpers
  logic [65:0]  sq_prod;
  logic [33:0]  x_sq;
  logic [4:0]   lead;
  logic [31:0]  m1_nz;
  logic [46:0]  sq_try;
  logic [35:0]  dx;
  logic [35:0]  dy;
  logic [33:0]  at;
  logic [31:0]  d_res;
  logic [1:0]   q_next;
  logic [15:0]  sat_a;
  logic [15:0]  sat_b;
  logic [14:0]  max_next;
  logic [14:0]  max_base;

  assign job_ready = (state == B_IDLE);
  assign m1_nz     = (job.m1 == 32'd0) ? 32'd1 : job.m1;

  // leading-one search over the mantissa
  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (m1[i]) lead = 5'(i);
    end
  end

  // squaring step of the log mantissa
  assign sq_prod = {33'd0, x_log} * {33'd0, x_log};
  assign x_sq    = sq_prod[64:31];

  // square root trial
  assign sq_try = {1'b0, sq_res} + {1'b0, sq_bit};

  // cordic shifts and table
  assign dx = $signed(cy) >>> cnt;
  assign dy = $signed(cx) >>> cnt;
  assign at = {4'd0, atan_turn(cnt)};

  // quadrant split of the phase
  assign q_next = 2'(((m2 + 32'h20000000) >> 30));
  assign d_res  = m2 - {q_next, 30'd0};

  // rounding and saturation
  function automatic logic [15:0] to_out(input logic [35:0] v);
    logic [35:0] s;
    logic [35:0] o;
    s = v + (36'd1 << (OUT_SHIFT - 1));
    o = 36'($signed(s) >>> OUT_SHIFT);
    if (!o[35] && o > 36'd32767) return 16'h7FFF;
    if (o[35] && $signed(o) < -36'sd32768) return 16'h8000;
    return o[15:0];
  endfunction

  assign sat_a    = to_out(cx);
  assign sat_b    = to_out(cy);
  assign max_base = rmax;
  always_comb begin
    max_next = max_base;
    if (!sat_a[15] && sat_a[14:0] > max_next) max_next = sat_a[14:0];
    if (!sat_b[15] && sat_b[14:0] > max_next) max_next = sat_b[14:0];
  end

  // transform sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      rmax         <= 15'd0;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            m1 <= m1_nz;
            m2 <= job.m2;
            if (job.new_batch) rmax <= 15'd0;
            state <= B_NORM;
          end
        end
        B_NORM: begin
          e     <= lead;
          x_log <= 33'(m1 << (5'd31 - lead));
          frac  <= 28'd0;
          cnt   <= 5'd0;
          state <= B_LOG;
        end
        B_LOG: begin
          if (x_sq[33:32] != 2'd0) begin
            x_log <= x_sq[33:1];
            frac  <= {frac[26:0], 1'b1};
          end else begin
            x_log <= x_sq[32:0];
            frac  <= {frac[26:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(LOG_FRAC_BITS - 1)) state <= B_MUL;
        end
        B_MUL: begin
          lval  <= (34'd32 << LOG_FRAC_BITS) - {1'b0, e, frac};
          state <= B_SQRT;
          cnt   <= 5'd0;
        end
        B_SQRT: begin
          if (cnt == 5'd0) begin
            prod_l <= 64'(lval) * 64'(TWO_LN2_Q30);
            cnt    <= 5'd1;
          end else if (cnt == 5'd1) begin
            // r squared in q.28, scaled by 2^12 so the root lands in q.20
            sq_v   <= {prod_l[63:30], 12'd0};
            sq_res <= 46'd0;
            sq_bit <= 46'd1 << 44;
            cnt    <= 5'd2;
          end else begin
            if ({1'b0, sq_v} >= sq_try) begin
              sq_v   <= sq_v - sq_try[45:0];
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
            if (sq_bit[0]) state <= B_GAIN;
          end
        end
        B_GAIN: begin
          rad   <= 32'(sq_res);
          prod_l <= 64'(sq_res[22:0]) * 64'(CORDIC_GAIN_Q30);
          quad  <= q_next;
          cz    <= 34'($signed(d_res));
          cnt   <= 5'd0;
          state <= B_ROT;
        end
        B_ROT: begin
          if (cnt == 5'd0 && rad[31]) begin
            rad <= 32'd0;
          end
          if (cnt == 5'd0 && !rad[31]) begin
            cx  <= 36'(prod_l[63:20]);
            cy  <= 36'd0;
            rad[31] <= 1'b1;
          end else begin
            if (!cz[33]) begin
              cx <= cx - dx;
              cy <= cy + dy;
              cz <= cz - at;
            end else begin
              cx <= cx + dx;
              cy <= cy - dy;
              cz <= cz + at;
            end
            cnt <= cnt + 5'd1;
            if (cnt == 5'(CORDIC_ITERS - 1)) state <= B_QUAD;
          end
        end
        B_QUAD: begin
          case (quad)
            2'd1: begin cx <= -cy; cy <= cx; end
            2'd2: begin cx <= -cx; cy <= -cy; end
            2'd3: begin cx <= cy; cy <= -cx; end
            default: ;
          endcase
          state <= B_OUT;
        end
        B_OUT: begin
          oa           <= sat_a;
          ob           <= sat_b;
          rmax         <= max_next;
          out_ch.valid <= 1'b1;
          state        <= B_HOLD;
        end
        B_HOLD: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign out_ch.gauss_a   = oa;
  assign out_ch.gauss_b   = ob;
  assign out_ch.batch_max = rmax;
endmodule

[design/gaussian_pair_generator_running_max.sv]
// ----------------------------------------------------------------------------
// gaussian_pair_generator_running_max
// box-muller gaussian pairs from a 16807 multiplicative generator
// ----------------------------------------------------------------------------
// channel   dir  fields
// in_ch     in   new_batch, reseed
// out_ch    out  gauss_a, gauss_b, batch_max
// cfg       in   data (seed)
// the back part takes one word at a time and its 28-step log squaring,
// 23-step square root and 28 cordic rotations set the pace; the generator
// front runs ahead through a two-entry queue.
// synchronous reset loads seed 12345 into seed and generator state.
// a stalled output holds the back part; the front keeps filling the queue.
module gaussian_pair_generator_running_max (
  input  logic      clk,
  input  logic      rst,
  gpg_in_if.sink    in_ch,
  gpg_out_if.source out_ch,
  gpg_cfg_if.sink   cfg
);
  import gpg_pkg::*;
  `include "gaussian_pair_generator_running_max_assert.svh"

  logic     f_valid;
  logic     f_ready;
  gpg_job_t f_job;
  logic     b_valid;
  logic     b_ready;
  gpg_job_t b_job;

  gpg_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg),
    .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
  );

  gpg_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_data(f_job), .wr_ready(f_ready),
    .rd_valid(b_valid), .rd_data(b_job), .rd_ready(b_ready)
  );

  gpg_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(b_valid), .job(b_job), .job_ready(b_ready),
    .out_ch(out_ch)
  );

  // checks
  `GPG_ASSERT(a_out_known, !out_ch.valid ||
    !$isunknown({out_ch.gauss_a, out_ch.gauss_b, out_ch.batch_max}),
    "result word has unknown bits")
  `GPG_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid,
    "result dropped while stalled")
  `GPG_ASSERT_NEXT(a_out_stable, out_ch.valid && !out_ch.ready,
    $stable({out_ch.gauss_a, out_ch.gauss_b, out_ch.batch_max}),
    "result word changed while stalled")
endmodule
